FILE: hw/rtl/matinv_pkg.sv
// ----------------------------------------------------------------------------
// matinv_pkg
// Shared types and constants for the 3x3 Q16.16 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package matinv_pkg;

  localparam int ELEM_W     = 32;
  localparam int NELEM      = 9;
  localparam int ADJ_W      = 64;
  localparam int DET_W      = 97;
  localparam int DMAG_W     = 96;
  localparam int THR_W      = 16;
  localparam int QBITS      = 32;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = QBITS / DIV_STEPS;

  localparam logic [QBITS-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QBITS-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef elem_t [NELEM-1:0]        elem_vec_t;
  typedef adj_t  [NELEM-1:0]        adj_vec_t;

  typedef struct packed {
    elem_t m_r0c0;
    elem_t m_r0c1;
    elem_t m_r0c2;
    elem_t m_r1c0;
    elem_t m_r1c1;
    elem_t m_r1c2;
    elem_t m_r2c0;
    elem_t m_r2c1;
    elem_t m_r2c2;
  } matinv_in_t;

  typedef struct packed {
    elem_t inv_r0c0;
    elem_t inv_r0c1;
    elem_t inv_r0c2;
    elem_t inv_r1c0;
    elem_t inv_r1c1;
    elem_t inv_r1c2;
    elem_t inv_r2c0;
    elem_t inv_r2c1;
    elem_t inv_r2c2;
    logic  singular;
    logic  saturated;
  } matinv_out_t;

  // determinant magnitude and singular flag shared by all lanes of one item
  typedef struct packed {
    logic [DMAG_W-1:0] dmag;
    logic              singular;
  } det_info_t;

  // one element ready for division
  typedef struct packed {
    logic [ADJ_W-1:0] amag;
    logic             neg;
    logic             ovf;
  } lane_prep_t;

  typedef lane_prep_t [NELEM-1:0] lane_vec_t;

  // one element after division
  typedef struct packed {
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } quot_t;

  typedef quot_t [NELEM-1:0] quot_vec_t;

endpackage

FILE: hw/rtl/matinv_adj.sv
// ----------------------------------------------------------------------------
// matinv_adj
// Adjugate stages: cofactor products, then their differences.
// ----------------------------------------------------------------------------
module matinv_adj (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  matinv_pkg::elem_vec_t m_i,
  output logic                  valid_o,
  output matinv_pkg::elem_vec_t m_o,
  output matinv_pkg::adj_vec_t  adj_o
);
  import matinv_pkg::*;

  adj_t      pa_nxt [NELEM];
  adj_t      pb_nxt [NELEM];
  adj_t      pa_r   [NELEM];
  adj_t      pb_r   [NELEM];
  elem_vec_t m1_r;
  logic      v1_r;
  adj_vec_t  adj_nxt;
  adj_vec_t  adj_r;
  elem_vec_t m2_r;
  logic      v2_r;

  // adjugate row r is the cross product of columns r+1 and r+2
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int A = (r + 1) % 3;
      localparam int B = (r + 2) % 3;
      localparam int Y = (c + 1) % 3;
      localparam int Z = (c + 2) % 3;
      assign pa_nxt[r*3+c] = $signed(m_i[Y*3+A]) * $signed(m_i[Z*3+B]);
      assign pb_nxt[r*3+c] = $signed(m_i[Z*3+A]) * $signed(m_i[Y*3+B]);
    end
  end

  always_comb begin
    for (int i = 0; i < NELEM; i++) begin
      adj_nxt[i] = pa_r[i] - pb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      m1_r  <= m_i;
      adj_r <= adj_nxt;
      m2_r  <= m1_r;
    end
  end

  assign valid_o = v2_r;
  assign m_o     = m2_r;
  assign adj_o   = adj_r;

endmodule

FILE: hw/rtl/matinv_det.sv
// ----------------------------------------------------------------------------
// matinv_det
// Determinant stages: split products, term sums, total, magnitude and
// singular test, plus per-element sign and overflow prep for the divider.
// ----------------------------------------------------------------------------
module matinv_det (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [matinv_pkg::THR_W-1:0]       thr,
  input  logic                               valid_i,
  input  matinv_pkg::elem_vec_t              m_i,
  input  matinv_pkg::adj_vec_t               adj_i,
  output logic                               valid_o,
  output matinv_pkg::elem_vec_t              m_o,
  output matinv_pkg::lane_vec_t              lane_o,
  output matinv_pkg::det_info_t              info_o
);
  import matinv_pkg::*;

  // stage 3: 32x32 partial products of adj row 2 times column 2
  logic signed [ADJ_W:0]     pl_nxt [3];
  logic signed [ADJ_W-1:0]   ph_nxt [3];
  logic signed [ADJ_W:0]     pl_r   [3];
  logic signed [ADJ_W-1:0]   ph_r   [3];
  adj_vec_t                  adj3_r;
  elem_vec_t                 m3_r;
  logic                      v3_r;
  // stage 4: recombined terms
  logic signed [DMAG_W-1:0]  term_nxt [3];
  logic signed [DMAG_W-1:0]  term_r   [3];
  adj_vec_t                  adj4_r;
  elem_vec_t                 m4_r;
  logic                      v4_r;
  // stage 5: determinant and adjugate magnitudes
  logic signed [DET_W-1:0]   det_nxt;
  logic signed [DET_W-1:0]   det_r;
  logic [ADJ_W-1:0]          amag_nxt [NELEM];
  logic [ADJ_W-1:0]          amag_r   [NELEM];
  logic [NELEM-1:0]          aneg_r;
  elem_vec_t                 m5_r;
  logic                      v5_r;
  // stage 6
  logic [DET_W-1:0]          dabs;
  logic [DMAG_W-1:0]         dmag;
  lane_vec_t                 lane_nxt;
  det_info_t                 info_nxt;
  lane_vec_t                 lane_r;
  det_info_t                 info_r;
  elem_vec_t                 m6_r;
  logic                      v6_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pl_nxt[k] = $signed({1'b0, adj_i[6+k][ELEM_W-1:0]}) * $signed(m_i[3*k+2]);
      ph_nxt[k] = $signed(adj_i[6+k][ADJ_W-1:ELEM_W]) * $signed(m_i[3*k+2]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_nxt[k] = {ph_r[k], {ELEM_W{1'b0}}}
                  + {{(DMAG_W-ADJ_W-1){pl_r[k][ADJ_W]}}, pl_r[k]};
    end
  end

  always_comb begin
    det_nxt = {term_r[0][DMAG_W-1], term_r[0]}
            + {term_r[1][DMAG_W-1], term_r[1]}
            + {term_r[2][DMAG_W-1], term_r[2]};
    for (int i = 0; i < NELEM; i++) begin
      amag_nxt[i] = adj4_r[i][ADJ_W-1] ? ADJ_W'(-adj4_r[i]) : adj4_r[i];
    end
  end

  always_comb begin
    // |det| stays below 2^96, so the top bit of the magnitude is dropped
    dabs = det_r[DET_W-1] ? DET_W'(-det_r) : det_r;
    dmag = dabs[DMAG_W-1:0];
    info_nxt.dmag     = dmag;
    info_nxt.singular = dmag[DMAG_W-1:QBITS] <= {{(DMAG_W-QBITS-THR_W){1'b0}}, thr};
    for (int i = 0; i < NELEM; i++) begin
      lane_nxt[i].amag = amag_r[i];
      lane_nxt[i].neg  = aneg_r[i] ^ det_r[DET_W-1];
      // quotient of (a << 32) / dmag reaches 2^32 exactly when a >= dmag
      lane_nxt[i].ovf  = {{(DMAG_W-ADJ_W){1'b0}}, amag_r[i]} >= dmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v3_r <= valid_i;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      adj3_r <= adj_i;
      m3_r   <= m_i;
      term_r <= term_nxt;
      adj4_r <= adj3_r;
      m4_r   <= m3_r;
      det_r  <= det_nxt;
      amag_r <= amag_nxt;
      for (int i = 0; i < NELEM; i++) begin
        aneg_r[i] <= adj4_r[i][ADJ_W-1];
      end
      m5_r   <= m4_r;
      lane_r <= lane_nxt;
      info_r <= info_nxt;
      m6_r   <= m5_r;
    end
  end

  assign valid_o = v6_r;
  assign m_o     = m6_r;
  assign lane_o  = lane_r;
  assign info_o  = info_r;

endmodule

FILE: hw/rtl/matinv_div.sv
// ----------------------------------------------------------------------------
// matinv_div
// Restoring division, nine lanes side by side, DIV_STEPS quotient bits per
// register stage.
// ----------------------------------------------------------------------------
module matinv_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  matinv_pkg::elem_vec_t m_i,
  input  matinv_pkg::lane_vec_t lane_i,
  input  matinv_pkg::det_info_t info_i,
  output logic                  valid_o,
  output matinv_pkg::elem_vec_t m_o,
  output matinv_pkg::quot_vec_t quot_o,
  output logic                  singular_o
);
  import matinv_pkg::*;

  logic [DMAG_W-1:0]     rem_r  [DIV_STAGES][NELEM];
  logic [QBITS-1:0]      q_r    [DIV_STAGES][NELEM];
  logic [NELEM-1:0]      neg_r  [DIV_STAGES];
  logic [NELEM-1:0]      ovf_r  [DIV_STAGES];
  det_info_t             info_r [DIV_STAGES];
  elem_vec_t             m_r    [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DMAG_W-1:0] rem_in  [NELEM];
    logic [QBITS-1:0]  q_in    [NELEM];
    logic [NELEM-1:0]  neg_in;
    logic [NELEM-1:0]  ovf_in;
    det_info_t         info_in;
    elem_vec_t         m_in;
    logic              vld_in;
    logic [DMAG_W-1:0] rem_nxt [NELEM];
    logic [QBITS-1:0]  q_nxt   [NELEM];

    if (s == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < NELEM; i++) begin
          rem_in[i] = {{(DMAG_W-ADJ_W){1'b0}}, lane_i[i].amag};
          q_in[i]   = '0;
          neg_in[i] = lane_i[i].neg;
          ovf_in[i] = lane_i[i].ovf;
        end
        info_in = info_i;
        m_in    = m_i;
        vld_in  = valid_i;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem_r[s-1];
        q_in    = q_r[s-1];
        neg_in  = neg_r[s-1];
        ovf_in  = ovf_r[s-1];
        info_in = info_r[s-1];
        m_in    = m_r[s-1];
        vld_in  = vld_r[s-1];
      end
    end

    always_comb begin
      logic [DMAG_W:0]   t;
      logic [DMAG_W-1:0] rem;
      logic [QBITS-1:0]  q;
      for (int i = 0; i < NELEM; i++) begin
        rem = rem_in[i];
        q   = q_in[i];
        for (int j = 0; j < DIV_STEPS; j++) begin
          t = {rem, 1'b0};
          if (t >= {1'b0, info_in.dmag}) begin
            t = t - {1'b0, info_in.dmag};
            q = {q[QBITS-2:0], 1'b1};
          end else begin
            q = {q[QBITS-2:0], 1'b0};
          end
          rem = t[DMAG_W-1:0];
        end
        rem_nxt[i] = rem;
        q_nxt[i]   = q;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        neg_r[s]  <= neg_in;
        ovf_r[s]  <= ovf_in;
        info_r[s] <= info_in;
        m_r[s]    <= m_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NELEM; i++) begin
      quot_o[i].q   = q_r[DIV_STAGES-1][i];
      quot_o[i].neg = neg_r[DIV_STAGES-1][i];
      quot_o[i].ovf = ovf_r[DIV_STAGES-1][i];
    end
  end

  assign valid_o    = vld_r[DIV_STAGES-1];
  assign m_o        = m_r[DIV_STAGES-1];
  assign singular_o = info_r[DIV_STAGES-1].singular;

endmodule

FILE: hw/rtl/matrix3_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_top
// 3x3 Q16.16 matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                         direction  meaning
//  in        in_valid/in_ready/in_data     input      one matrix per item
//  out       out_valid/out_ready/out_data  output     inverse, singular, saturated
//  cfg       cfg_wr_en/cfg_wr_data         input      zero threshold, Q0.16
//
//  one item per cycle while the output is not held; stages: 2 adjugate,
//  4 determinant, 8 divider stages of 4 quotient bits each, 1 output register.
//  reset clears all valid bits and sets the threshold to zero.
//  a held output item stalls the whole pipeline; in_ready follows
//  !out_valid || out_ready.
// ----------------------------------------------------------------------------
module matrix3_inverse_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  matinv_pkg::matinv_in_t           in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output matinv_pkg::matinv_out_t          out_data,
  input  logic                             cfg_wr_en,
  input  logic [matinv_pkg::THR_W-1:0]     cfg_wr_data
);
  import matinv_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             adv;
  elem_vec_t        m_in;
  logic             adj_valid;
  elem_vec_t        adj_m;
  adj_vec_t         adj_val;
  logic             det_valid;
  elem_vec_t        det_m;
  lane_vec_t        det_lane;
  det_info_t        det_info;
  logic             div_valid;
  elem_vec_t        div_m;
  quot_vec_t        div_quot;
  logic             div_singular;
  matinv_out_t      out_nxt;
  matinv_out_t      out_data_r;
  logic             out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign m_in[0] = in_data.m_r0c0;
  assign m_in[1] = in_data.m_r0c1;
  assign m_in[2] = in_data.m_r0c2;
  assign m_in[3] = in_data.m_r1c0;
  assign m_in[4] = in_data.m_r1c1;
  assign m_in[5] = in_data.m_r1c2;
  assign m_in[6] = in_data.m_r2c0;
  assign m_in[7] = in_data.m_r2c1;
  assign m_in[8] = in_data.m_r2c2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  matinv_adj u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_valid),
    .m_i     (m_in),
    .valid_o (adj_valid),
    .m_o     (adj_m),
    .adj_o   (adj_val)
  );

  matinv_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .thr     (thr_r),
    .valid_i (adj_valid),
    .m_i     (adj_m),
    .adj_i   (adj_val),
    .valid_o (det_valid),
    .m_o     (det_m),
    .lane_o  (det_lane),
    .info_o  (det_info)
  );

  matinv_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .valid_i    (det_valid),
    .m_i        (det_m),
    .lane_i     (det_lane),
    .info_i     (det_info),
    .valid_o    (div_valid),
    .m_o        (div_m),
    .quot_o     (div_quot),
    .singular_o (div_singular)
  );

  // sign, clamp and singular pass-through
  always_comb begin
    elem_vec_t        res;
    logic             sat_any;
    logic             over;
    logic [QBITS-1:0] q;
    sat_any = 1'b0;
    for (int i = 0; i < NELEM; i++) begin
      q    = div_quot[i].q;
      over = div_quot[i].ovf || (div_quot[i].neg ? (q > SAT_NEG) : (q > SAT_POS));
      if (over) begin
        res[i] = div_quot[i].neg ? SAT_NEG : SAT_POS;
      end else begin
        res[i] = div_quot[i].neg ? QBITS'(-q) : q;
      end
      sat_any = sat_any | over;
    end
    if (div_singular) begin
      res     = div_m;
      sat_any = 1'b0;
    end
    out_nxt.inv_r0c0  = res[0];
    out_nxt.inv_r0c1  = res[1];
    out_nxt.inv_r0c2  = res[2];
    out_nxt.inv_r1c0  = res[3];
    out_nxt.inv_r1c1  = res[4];
    out_nxt.inv_r1c2  = res[5];
    out_nxt.inv_r2c0  = res[6];
    out_nxt.inv_r2c1  = res[7];
    out_nxt.inv_r2c2  = res[8];
    out_nxt.singular  = div_singular;
    out_nxt.saturated = sat_any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/matinv_chk.sv
// ----------------------------------------------------------------------------
// matinv_chk
// Port-level checks for the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module matinv_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input matinv_pkg::matinv_out_t out_data
);
  import matinv_pkg::*;

  logic any_clamp;

  assign any_clamp = (out_data.inv_r0c0 == SAT_POS) || (out_data.inv_r0c0 == SAT_NEG)
                  || (out_data.inv_r0c1 == SAT_POS) || (out_data.inv_r0c1 == SAT_NEG)
                  || (out_data.inv_r0c2 == SAT_POS) || (out_data.inv_r0c2 == SAT_NEG)
                  || (out_data.inv_r1c0 == SAT_POS) || (out_data.inv_r1c0 == SAT_NEG)
                  || (out_data.inv_r1c1 == SAT_POS) || (out_data.inv_r1c1 == SAT_NEG)
                  || (out_data.inv_r1c2 == SAT_POS) || (out_data.inv_r1c2 == SAT_NEG)
                  || (out_data.inv_r2c0 == SAT_POS) || (out_data.inv_r2c0 == SAT_NEG)
                  || (out_data.inv_r2c1 == SAT_POS) || (out_data.inv_r2c1 == SAT_NEG)
                  || (out_data.inv_r2c2 == SAT_POS) || (out_data.inv_r2c2 == SAT_NEG);

  // a held result item keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // an empty output slot never blocks the input
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // pass-through items never report clamping
  a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> !out_data.saturated)
    else $error("singular item flagged saturated");

  // a clamp flag always comes with a clamped element
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> any_clamp)
    else $error("saturated item without a clamped element");

endmodule

bind matrix3_inverse_top matinv_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
